[rtl/shuffled_lehmer_uniform_rng_core_macros.svh]
// ----------------------------------------------------------------------------
// shuffled lehmer rng assertion macros
// concurrent assertion helpers clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef SHUFFLED_LEHMER_UNIFORM_RNG_CORE_MACROS_SVH
`define SHUFFLED_LEHMER_UNIFORM_RNG_CORE_MACROS_SVH

`ifndef SYNTH

// condition must hold at every edge out of reset
`define SLURNG_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("slurng assertion failed");

// antecedent implies consequent at the next edge
`define SLURNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slurng assertion failed");

`else

`define SLURNG_ASSERT_ALWAYS(lbl, cond)
`define SLURNG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/slurng_pkg.sv]
// ----------------------------------------------------------------------------
// slurng_pkg
// shared constants and controller to datapath command bundle
// ----------------------------------------------------------------------------
package slurng_pkg;

  // lehmer generator constants
  localparam logic [30:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [14:0] LEHMER_MUL = 15'd16807;
  localparam logic [30:0] OUT_MAX    = 31'd2147483389;
  localparam logic [30:0] SEED_ONE   = 31'd1;

  // per-cycle commands from the controller
  typedef struct packed {
    logic load_seed;   // state <= sanitized seed
    logic step;        // state <= next(state)
    logic fill;        // table[index] <= next(state), last <= next(state)
    logic div_start;   // quotient <= last output / bucket width
    logic read;        // read table at pick into read register
    logic commit;      // swap in new entry, update last output and result
  } cmd_t;

endpackage

[rtl/shuffled_lehmer_uniform_rng_core.sv]
// ----------------------------------------------------------------------------
// shuffled_lehmer_uniform_rng_core
// park-miller generator behind a bays-durham shuffle table
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one request (draw_request);
//   a request with draw_request high yields one uniform_numerator on the
//   out_valid/out_ready channel, a request with it low yields nothing.
//   seed_we/seed_wdata write the seed and force a re-init at the next draw;
//   write the seed only while the block is idle.
// draw sequence:
//   after the accept, the draw passes the pick (a registered reciprocal
//   multiply of the last output), the registered table read and the swap,
//   which sets out_valid and returns to idle; a new request is taken only
//   once the previous draw has been swapped in.
//   the first draw after reset or a seed write first loads the seed, then
//   runs WARMUP_STEPS warm-up steps and fills all TABLE_ENTRIES entries.
// reset clears control state and sets the seed to 1; the table is filled
// at first draw.
// a stalled receiver holds the result; the next request may be accepted
// and computed, and waits in its swap step until the result is taken.
// ----------------------------------------------------------------------------
`include "shuffled_lehmer_uniform_rng_core_macros.svh"

module shuffled_lehmer_uniform_rng_core #(
  parameter int TABLE_ENTRIES = 32,
  parameter int WARMUP_STEPS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [30:0] seed_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        draw_request,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] uniform_numerator
);

  localparam int CNT_A   = (WARMUP_STEPS > TABLE_ENTRIES) ? WARMUP_STEPS : TABLE_ENTRIES;
  localparam int CNT_W   = $clog2(CNT_A + 1);

  slurng_pkg::cmd_t   cmd;
  logic [CNT_W-1:0]   cmd_index;

  // sequencer
  slurng_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .WARMUP_STEPS  (WARMUP_STEPS),
    .CNT_W         (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .seed_we      (seed_we),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .draw_request (draw_request),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .cmd_index    (cmd_index)
  );

  // generator, table and result register
  slurng_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .seed_we           (seed_we),
    .seed_wdata        (seed_wdata),
    .cmd               (cmd),
    .cmd_index         (cmd_index),
    .uniform_numerator (uniform_numerator)
  );

  // result always within the saturated nonzero range
  `SLURNG_ASSERT_ALWAYS(a_result_range, !out_valid || (uniform_numerator != 31'd0 && uniform_numerator <= slurng_pkg::OUT_MAX))

  // a draw request leaves the idle state
  `SLURNG_ASSERT_NEXT(a_draw_busy, in_valid && in_ready && draw_request, !in_ready)

  // a new result is only produced outside the idle state
  `SLURNG_ASSERT_ALWAYS(a_result_from_busy, !$rose(out_valid) || !$past(in_ready))

endmodule

[rtl/slurng_dp.sv]
// ----------------------------------------------------------------------------
// slurng_dp
// lehmer step unit, shuffle table memory, pick multiplier and result register
// ----------------------------------------------------------------------------
module slurng_dp #(
  parameter int TABLE_ENTRIES = 32,
  parameter int CNT_W         = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                seed_we,
  input  logic [30:0]         seed_wdata,
  input  slurng_pkg::cmd_t    cmd,
  input  logic [CNT_W-1:0]    cmd_index,
  output logic [30:0]         uniform_numerator
);

  localparam int IW       = $clog2(TABLE_ENTRIES);
  localparam int QW       = $clog2(TABLE_ENTRIES + 1);
  localparam int DIV_D    = 1 + (2147483646 / TABLE_ENTRIES);
  localparam int DIV_L    = $clog2(DIV_D);
  localparam int PICK_LSB = 31 + DIV_L;
  // ceil(2^(31+l) / d) gives an exact quotient for every 31-bit dividend
  localparam logic [31:0] DIV_RECIP =
    32'(((longint'(1) << PICK_LSB) + longint'(DIV_D) - 1) / longint'(DIV_D));

  logic [30:0]       seed_value;
  logic [30:0]       lehmer_state;
  logic [30:0]       last_output;
  logic [30:0]       rdata;
  logic [QW-1:0]     quot;
  logic [30:0]       mem [TABLE_ENTRIES];

  logic [45:0]       prod;
  logic [31:0]       fold;
  logic [30:0]       state_next;
  logic [30:0]       seed_fixed;
  logic [IW-1:0]     pick;
  logic [62:0]       pick_prod;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [30:0]       mem_wdata;

  // multiply by 16807 and fold modulo 2^31-1
  assign prod       = 46'(lehmer_state) * 46'(slurng_pkg::LEHMER_MUL);
  assign fold       = {1'b0, prod[30:0]} + 32'(prod[45:31]);
  assign state_next = (fold >= {1'b0, slurng_pkg::LEHMER_MOD}) ?
                      31'(fold - {1'b0, slurng_pkg::LEHMER_MOD}) : fold[30:0];

  // zero or all-ones seed would lock the generator
  assign seed_fixed = (seed_value == '0 || seed_value == slurng_pkg::LEHMER_MOD) ?
                      slurng_pkg::SEED_ONE : seed_value;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= slurng_pkg::SEED_ONE;
    end else if (seed_we) begin
      seed_value <= seed_wdata;
    end
  end

  // generator state
  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      lehmer_state <= seed_fixed;
    end else if (cmd.step) begin
      lehmer_state <= state_next;
    end
  end

  // last output over the bucket width by reciprocal multiply
  assign pick_prod = {32'd0, last_output} * {31'd0, DIV_RECIP};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quot <= pick_prod[PICK_LSB+QW-1:PICK_LSB];
    end
  end

  // clamp pick to the last entry
  assign pick = (quot >= QW'(TABLE_ENTRIES)) ? IW'(TABLE_ENTRIES - 1) : quot[IW-1:0];

  // table write port: fill during init, swap on commit
  assign mem_we    = cmd.fill | cmd.commit;
  assign mem_waddr = cmd.fill ? cmd_index[IW-1:0] : pick;
  assign mem_wdata = cmd.fill ? state_next : lehmer_state;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rdata <= mem[pick];
    end
  end

  // last output and saturated result
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      last_output <= state_next;
    end else if (cmd.commit) begin
      last_output <= rdata;
    end
    if (cmd.commit) begin
      uniform_numerator <= (rdata > slurng_pkg::OUT_MAX) ? slurng_pkg::OUT_MAX : rdata;
    end
  end

endmodule

[rtl/slurng_ctrl.sv]
// ----------------------------------------------------------------------------
// slurng_ctrl
// request sequencer: init, warm-up, table fill, pick and swap
// ----------------------------------------------------------------------------
module slurng_ctrl #(
  parameter int TABLE_ENTRIES = 32,
  parameter int WARMUP_STEPS  = 8,
  parameter int CNT_W         = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_we,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              draw_request,
  output logic              out_valid,
  input  logic              out_ready,
  output slurng_pkg::cmd_t  cmd,
  output logic [CNT_W-1:0]  cmd_index
);

  localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'((WARMUP_STEPS > 0) ? WARMUP_STEPS - 1 : 0);
  localparam logic [CNT_W-1:0] FILL_LAST = CNT_W'(TABLE_ENTRIES - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b00_0001,
    S_SEED   = 6'b00_0010,
    S_WARM   = 6'b00_0100,
    S_FILL   = 6'b00_1000,
    S_DLOAD  = 6'b01_0000,
    S_COMMIT = 6'b10_0000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              initialized, initialized_next;
  logic              out_valid_next;
  logic              read_pending, read_pending_next;
  logic              accept;
  logic              commit_ok;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid & in_ready;
  assign commit_ok = ~out_valid | out_ready;
  assign cmd_index = cnt;

  // next state and commands
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    initialized_next  = initialized;
    read_pending_next = read_pending;
    out_valid_next    = out_valid & ~out_ready;
    cmd               = '0;
    case (state)
      S_IDLE: begin
        if (seed_we) begin
          initialized_next = 1'b0;
        end
        if (accept && draw_request) begin
          state_next = (initialized && !seed_we) ? S_DLOAD : S_SEED;
        end
      end
      S_SEED: begin
        cmd.load_seed = 1'b1;
        if (WARMUP_STEPS > 0) begin
          state_next = S_WARM;
          cnt_next   = WARM_LAST;
        end else begin
          state_next = S_FILL;
          cnt_next   = FILL_LAST;
        end
      end
      S_WARM: begin
        cmd.step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FILL;
          cnt_next   = FILL_LAST;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FILL: begin
        cmd.step = 1'b1;
        cmd.fill = 1'b1;
        if (cnt == '0) begin
          state_next       = S_DLOAD;
          initialized_next = 1'b1;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_DLOAD: begin
        cmd.div_start     = 1'b1;
        state_next        = S_COMMIT;
        read_pending_next = 1'b1;
      end
      S_COMMIT: begin
        // while a read is pending, read the table and step the generator
        if (read_pending) begin
          cmd.read          = 1'b1;
          cmd.step          = 1'b1;
          read_pending_next = 1'b0;
        end else if (commit_ok) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      initialized  <= 1'b0;
      read_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      initialized  <= initialized_next;
      read_pending <= read_pending_next;
      out_valid    <= out_valid_next;
    end
  end

endmodule

[bench/uniform_draw_checker.sv]
// ----------------------------------------------------------------------------
// uniform_draw_checker
// watches the seed port and both request/result channels of the shuffled
// lehmer rng, keeps its own generator and shuffle table, predicts every
// uniform numerator and compares each delivered result in order
// ----------------------------------------------------------------------------
module uniform_draw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [30:0] seed_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        draw_request,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [30:0] uniform_numerator,
  output int          error_count,
  output int          outstanding,
  output int          draws_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ENTRIES      = 32;
  localparam int          WARMUP       = 8;
  localparam logic [30:0] MODULUS      = 31'h7FFF_FFFF;
  localparam logic [30:0] MULTIPLIER   = 31'd16807;
  localparam logic [30:0] SAT_LIMIT    = 31'd2147483389;
  localparam logic [31:0] PICK_DIVISOR = 32'd1 + (32'(MODULUS) - 32'd1) / ENTRIES;

  // model state
  logic [30:0] seed_reg;
  logic [30:0] gen_state;
  logic [30:0] last_draw;
  logic [30:0] shuffle [ENTRIES];
  bit          primed;
  int          errs = 0;
  int          checked = 0;

  // numerators predicted but not yet delivered, oldest first
  logic [30:0] expected_numerators [$];

  // one park-miller step
  function automatic logic [30:0] lehmer_advance(input logic [30:0] s);
    logic [63:0] prod;
    prod = 64'(s) * 64'(MULTIPLIER);
    return 31'(prod % 64'(MODULUS));
  endfunction

  // seed sanitize, warm-up, then fill the table from the top entry down
  function automatic void prime_table();
    logic [30:0] s;
    s = seed_reg;
    if (s == 31'd0 || s == MODULUS) s = 31'd1;
    repeat (WARMUP) s = lehmer_advance(s);
    for (int n = ENTRIES - 1; n >= 0; n--) begin
      s = lehmer_advance(s);
      shuffle[n] = s;
    end
    gen_state = s;
    last_draw = shuffle[0];
    primed = 1'b1;
  endfunction

  // advance the generator, swap through the table, saturate the output
  function automatic logic [30:0] predict_draw();
    logic [31:0] pick;
    if (!primed) prime_table();
    gen_state = lehmer_advance(gen_state);
    pick = 32'(last_draw) / PICK_DIVISOR;
    if (pick >= ENTRIES) pick = ENTRIES - 1;
    last_draw = shuffle[pick];
    shuffle[pick] = gen_state;
    return (last_draw > SAT_LIMIT) ? SAT_LIMIT : last_draw;
  endfunction

  // sample both channels and the seed port at each edge
  always @(posedge clk) begin
    logic [30:0] want;
    if (rst) begin
      seed_reg = 31'd1;
      gen_state = 31'd0;
      last_draw = 31'd0;
      primed = 1'b0;
      expected_numerators.delete();
    end else begin
      if (seed_we) begin
        seed_reg = seed_wdata;
        primed = 1'b0;
      end
      // a request without a draw yields nothing
      if (in_valid && in_ready && draw_request)
        expected_numerators.push_back(predict_draw());
      if (out_valid && out_ready) begin
        if (expected_numerators.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d", $time,
                   uniform_numerator);
          errs++;
        end else begin
          want = expected_numerators.pop_front();
          checked++;
          if (uniform_numerator !== want) begin
            $display("%0t: uniform_numerator mismatch, expected %0d, got %0d",
                     $time, want, uniform_numerator);
            errs++;
          end
        end
      end
    end
    error_count   <= errs;
    outstanding   <= expected_numerators.size();
    draws_checked <= checked;
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives draw requests and seed writes into the shuffled lehmer rng under
// several flow-control modes; the checker predicts and compares results
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 64;
  localparam int PER_MODE    = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seed_we = 1'b0;
  logic [30:0] seed_wdata = '0;
  logic        in_valid = 1'b0;
  logic        draw_request = 1'b0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [30:0] uniform_numerator;

  int error_count;
  int outstanding;
  int draws_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int empty_requests = 0;
  int seeds_written = 0;
  int cycles = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  shuffled_lehmer_uniform_rng_core u_top (
    .clk               (clk),
    .rst               (rst),
    .seed_we           (seed_we),
    .seed_wdata        (seed_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .draw_request      (draw_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .uniform_numerator (uniform_numerator)
  );

  uniform_draw_checker u_check (
    .clk               (clk),
    .rst               (rst),
    .seed_we           (seed_we),
    .seed_wdata        (seed_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .draw_request      (draw_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .uniform_numerator (uniform_numerator),
    .error_count       (error_count),
    .outstanding       (outstanding),
    .draws_checked     (draws_checked)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, with random idle cycles ahead of it
  task automatic send_request(input logic want_draw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    draw_request <= want_draw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
    if (!want_draw) empty_requests++;
  endtask

  // stop sending until every predicted result has been delivered
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // seed write once the block has drained, including any empty request
  task automatic write_seed(input logic [30:0] value);
    wait_idle();
    repeat (SETTLE) @(posedge clk);
    seed_we    <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we <= 1'b0;
    seeds_written++;
  endtask

  task automatic draw_burst(input int count);
    repeat (count) send_request(1'b1);
  endtask

  // mostly legal seeds, sometimes the extremes and the degenerate ones
  function automatic logic [30:0] pick_seed();
    case ($urandom_range(0, 7))
      0:       return 31'd1;
      1:       return 31'd2147483646;
      2:       return 31'd0;
      3:       return 31'h7FFF_FFFF;
      default: return 31'($urandom_range(1, 2147483646));
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset seed, empty request, degenerate and extreme seeds
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b1);
    write_seed(31'd0);
    draw_burst(3);
    write_seed(31'h7FFF_FFFF);
    draw_burst(3);
    write_seed(31'd2147483646);
    draw_burst(3);
    write_seed(31'd1);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    write_seed(31'h2AAA_AAAA);
    draw_burst(3);

    // random: one phase per flow-control mode, reseeding along the way
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      write_seed(pick_seed());
      for (int k = 0; k < PER_MODE; k++) begin
        if (k % 50 == 49) write_seed(pick_seed());
        // drain with no reseed, then carry on from the same table
        if (k == 120) wait_idle();
        send_request($urandom_range(0, 9) != 0);
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d requests (%0d with no draw), %0d results checked,",
             requests_sent, empty_requests, draws_checked);
    $display("%0d seed writes incl. degenerate seeds, four flow-control modes",
             seeds_written);
    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
